// ===== design/ctir_pkg.sv =====
// ----------------------------------------------------------------------------
// ctir_pkg
// Shared constants and stage payload for the IR-compensated color temperature
// pipeline.
// ----------------------------------------------------------------------------
package ctir_pkg;

  localparam int unsigned CNT_W      = 16;              // channel count width
  localparam int unsigned NUM_W      = 28;              // 3810 * 65535 < 2**28
  localparam int unsigned DIV_STEPS  = 4;               // quotient bits per stage
  localparam int unsigned DIV_STAGES = NUM_W / DIV_STEPS;

  localparam logic [CNT_W-1:0] CT_DIGITAL_SAT  = 16'd65535;
  localparam logic [11:0]      CT_SLOPE        = 12'd3810;
  localparam logic [CNT_W-1:0] CT_OFFSET       = 16'd1391;
  localparam logic [8:0]       CT_CYCLE_BASE   = 9'd256;
  localparam logic [8:0]       CT_CYCLE_LIMIT  = 9'd63;
  localparam logic [7:0]       ATIME_RESET     = 8'd255;

  // Divider working set: remaining dividend bits shift out of the top of nq
  // while quotient bits shift in at the bottom.
  typedef struct packed {
    logic             zero;   // force result to 0
    logic [CNT_W-1:0] den;    // red minus IR
    logic [CNT_W-1:0] rem;    // partial remainder
    logic [NUM_W-1:0] nq;     // dividend / quotient
  } ctir_div_t;

endpackage

// ===== design/color_temperature_ir_compensated.sv =====
// ----------------------------------------------------------------------------
// color_temperature_ir_compensated
// Structure: 10 register stages (2 front, 7 divider stages of 4 quotient bits
// each, 1 output register); every sample passes through them in that order.
// Throughput: one sample per cycle unless result_ready stalls the pipeline; the 28-bit pipelined divider sets depth.
// Reset: synchronous, active high; clears all stage valid bits and sets
// atime to 255 (one integration cycle).
// ----------------------------------------------------------------------------
module color_temperature_ir_compensated import ctir_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // configuration: atime
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data,
  // sample channel
  input  logic             sample_valid,
  output logic             sample_ready,
  input  logic [CNT_W-1:0] clear_count,
  input  logic [CNT_W-1:0] red_count,
  input  logic [CNT_W-1:0] green_count,
  input  logic [CNT_W-1:0] blue_count,
  // result channel
  output logic             result_valid,
  input  logic             result_ready,
  output logic [CNT_W-1:0] cct_kelvin
);

  // Integration setting. The user must write it only while the pipeline is empty
  // (the block itself does not enforce this), so the front stage reads it directly.
  logic [7:0] atime;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      atime <= ATIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      atime <= cfg_data;
    end
  end

  // Stage handshake chain: every stage holds its item when the next is full
  // and stalled, so a stall anywhere backs up without loss or repeat.
  logic      div_valid [DIV_STAGES+1];
  logic      div_ready [DIV_STAGES+1];
  ctir_div_t div_data  [DIV_STAGES+1];

  // Front: saturation check, IR estimate, red'/blue', 3810 * blue'.
  ctir_front u_front (
    .clk         (clk),
    .rst         (rst),
    .atime       (atime),
    .in_valid    (sample_valid),
    .in_ready    (sample_ready),
    .clear_count (clear_count),
    .red_count   (red_count),
    .green_count (green_count),
    .blue_count  (blue_count),
    .out_valid   (div_valid[0]),
    .out_ready   (div_ready[0]),
    .out_data    (div_data[0])
  );

  // Restoring divider, 3810 * blue' / red', DIV_STEPS bits per stage.
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    ctir_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[s]),
      .in_ready  (div_ready[s]),
      .in_data   (div_data[s]),
      .out_valid (div_valid[s+1]),
      .out_ready (div_ready[s+1]),
      .out_data  (div_data[s+1])
    );
  end

  // Offset add (low 16 bits), zero for invalid or saturated samples.
  ctir_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid[DIV_STAGES]),
    .in_ready  (div_ready[DIV_STAGES]),
    .in_data   (div_data[DIV_STAGES]),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .cct       (cct_kelvin)
  );

endmodule

// ===== design/ctir_front.sv =====
// ----------------------------------------------------------------------------
// ctir_front
// Validity checks, IR estimate, wrapped differences and the 3810 * blue'
// product; two register stages.
// ----------------------------------------------------------------------------
module ctir_front import ctir_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       atime,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CNT_W-1:0] clear_count,
  input  logic [CNT_W-1:0] red_count,
  input  logic [CNT_W-1:0] green_count,
  input  logic [CNT_W-1:0] blue_count,
  output logic             out_valid,
  input  logic             out_ready,
  output ctir_div_t        out_data
);

  logic             a_valid;
  logic             a_zero;
  logic [CNT_W-1:0] a_r2;
  logic [CNT_W-1:0] a_b2;
  logic             a_ready;
  logic             b_valid;
  logic             b_ready;
  ctir_div_t        b_data;

  logic [8:0]       cycles;
  logic [CNT_W-1:0] sat_level;
  logic [17:0]      sum;
  logic [17:0]      excess;
  logic [CNT_W-1:0] ir;
  logic             zero_next;
  logic [CNT_W-1:0] r2_next;
  logic [CNT_W-1:0] b2_next;

  // level = 768 * cycles below the digital limit
  always_comb begin
    cycles = CT_CYCLE_BASE - {1'b0, atime};
    if (cycles > CT_CYCLE_LIMIT) begin
      sat_level = CT_DIGITAL_SAT;
    end else begin
      sat_level = {2'b00, cycles[5:0], 8'h00} + {1'b0, cycles[5:0], 9'h000};
    end
    sum       = {2'b00, red_count} + {2'b00, green_count} + {2'b00, blue_count};
    excess    = sum - {2'b00, clear_count};
    ir        = (sum > {2'b00, clear_count}) ? excess[16:1] : '0;
    r2_next   = red_count - ir;
    b2_next   = blue_count - ir;
    zero_next = (clear_count == '0) || (clear_count >= sat_level);
  end

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_zero <= zero_next;
      a_r2   <= r2_next;
      a_b2   <= b2_next;
    end
    if (b_ready && a_valid) begin
      b_data.zero <= a_zero || (a_r2 == '0);
      b_data.den  <= a_r2;
      b_data.rem  <= '0;
      b_data.nq   <= NUM_W'(a_b2) * NUM_W'(CT_SLOPE);
    end
  end

  assign out_valid = b_valid;
  assign out_data  = b_data;

endmodule

// ===== design/ctir_div_stage.sv =====
// ----------------------------------------------------------------------------
// ctir_div_stage
// One registered slice of the restoring divider: DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
module ctir_div_stage import ctir_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctir_div_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ctir_div_t out_data
);

  logic      valid;
  ctir_div_t data;
  ctir_div_t data_next;

  always_comb begin
    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    rem = in_data.rem;
    nq  = in_data.nq;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem, nq[NUM_W-1]};
      nq    = {nq[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, in_data.den}) begin
        trial = trial - {1'b0, in_data.den};
        nq[0] = 1'b1;
      end
      rem = trial[CNT_W-1:0];
    end
    data_next      = in_data;
    data_next.rem  = rem;
    data_next.nq   = nq;
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule

// ===== design/ctir_back.sv =====
// ----------------------------------------------------------------------------
// ctir_back
// Output register: adds the offset to the quotient or forces 0.
// ----------------------------------------------------------------------------
module ctir_back import ctir_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ctir_div_t        in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CNT_W-1:0] cct
);

  logic             valid;
  logic [CNT_W-1:0] cct_reg;

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cct_reg <= in_data.zero ? '0 : in_data.nq[CNT_W-1:0] + CT_OFFSET;
    end
  end

  assign out_valid = valid;
  assign cct       = cct_reg;

endmodule
